// ===== src/g2e_pkg.sv =====
// g2e_pkg: shared constants, latencies and helpers for the geodetic to ecef pipeline
// no dependencies; imported by every module of the block but g2e_dly
package g2e_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 23;

  localparam int MUL_LAT      = 2;
  localparam int CELL_LAT     = 2 * MUL_LAT + 2;
  localparam int TAYLOR_TERMS = 12;
  localparam int SC_LAT       = 1 + 2 * MUL_LAT + TAYLOR_TERMS * CELL_LAT + 1;

  localparam int ROOT_STEPS = 61;
  localparam int ROOT_W     = 61;
  localparam int RDC_W      = 122;
  localparam int REM_W      = 66;
  localparam int QUOT_BITS  = 53;
  localparam int DIV_W      = 113;
  localparam int RAD_LAT    = ROOT_STEPS + QUOT_BITS;

  localparam logic [63:0] EQ_RADIUS_MM = 64'd6378137000;
  localparam logic signed [63:0] ONE_Q60 = 64'sd1 <<< 60;
  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] DEG_Q60 = PI_Q60 / 64'd180;

  localparam logic [127:0] FQ_W   = (128'd1000000000 << 60) / 128'd298257223563;
  localparam logic [127:0] E2_W   = (FQ_W << 1) - ((FQ_W * FQ_W) >> 60);
  localparam logic [127:0] OMF_W  = (128'd1 << 60) - FQ_W;
  localparam logic [127:0] OMF2_W = (OMF_W * OMF_W) >> 60;
  localparam logic [63:0] E2_Q60   = E2_W[63:0];
  localparam logic [63:0] OMF2_Q60 = OMF2_W[63:0];

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    logic [63:0] u;
    u = v;
    return v[63] ? (~u + 64'd1) : u;
  endfunction

endpackage

// ===== src/geodetic_to_ecef.sv =====
// WGS-84 geodetic to earth-centered earth-fixed conversion. One request is taken every clock
// cycle while in_stall is low, and results leave in the order of their requests.
// The path runs through four rows of 12 taylor cells for the sines and cosines, a 61-stage
// square root and a 53-stage divider for the radius, and the multipliers.
// A two-entry output buffer holds finished results, and in_stall rises only when it is full.
// Depends on g2e_pkg, g2e_dly, g2e_mul, g2e_sincos, g2e_radius.
module geodetic_to_ecef import g2e_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [30:0] in_latitude,
  input  logic signed [31:0] in_longitude,
  input  logic signed [27:0] in_altitude,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [33:0] out_ecef_x,
  output logic signed [33:0] out_ecef_y,
  output logic signed [33:0] out_ecef_z
);

  localparam int T_SC  = SC_LAT;
  localparam int T_SQ  = T_SC + MUL_LAT;
  localparam int T_EW  = T_SQ + MUL_LAT;
  localparam int T_W   = T_EW + 1;
  localparam int T_N   = T_W + RAD_LAT;
  localparam int T_RAD = T_N + 1;
  localparam int T_PX  = T_RAD + MUL_LAT;
  localparam int T_OUT = T_PX + MUL_LAT + 1;
  localparam logic signed [63:0] RND_HALF = 64'sd1 <<< 19;

  logic en;
  logic [T_OUT-1:0] vld_r;
  logic signed [63:0] sp, cp, sl, cl;
  logic signed [63:0] ssq, ew, zm, px, xv, yv, zv;
  logic [61:0] w_r;
  logic [QUOT_BITS-1:0] nq;
  logic signed [27:0] alt_n, alt_z;
  logic signed [63:0] rad_r, zq_r;
  logic signed [63:0] cp_d, sp_d, sl_d, cl_d;
  logic signed [33:0] rx_r, ry_r, rz_r;
  logic signed [33:0] fx_r [2];
  logic signed [33:0] fy_r [2];
  logic signed [33:0] fz_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic push, pop;

  assign en       = (cnt_r != 2'd2);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[T_OUT-2:0], in_valid};
    end
  end

  g2e_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .LIMIT_DEG(90)) u_lat (
    .clk(clk), .en(en), .angle(32'(in_latitude)), .sin_q(sp), .cos_q(cp)
  );

  g2e_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .LIMIT_DEG(180)) u_lon (
    .clk(clk), .en(en), .angle(in_longitude), .sin_q(sl), .cos_q(cl)
  );

  g2e_mul #(.SHIFT(60)) u_mul_ssq (
    .clk(clk), .en(en), .a(mag64(sp)), .b(mag64(sp)), .neg(1'b0), .p(ssq)
  );

  g2e_mul #(.SHIFT(60)) u_mul_ew (
    .clk(clk), .en(en), .a(E2_Q60), .b(ssq), .neg(1'b0), .p(ew)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= 62'(ONE_Q60 - ew);
    end
  end

  g2e_radius u_radius (
    .clk(clk), .en(en), .w(w_r), .nq(nq)
  );

  g2e_dly #(.W(28), .D(T_N)) u_dly_alt (
    .clk(clk), .en(en), .din(in_altitude), .dout(alt_n)
  );

  g2e_dly #(.W(28), .D(MUL_LAT)) u_dly_altz (
    .clk(clk), .en(en), .din(alt_n), .dout(alt_z)
  );

  g2e_mul #(.SHIFT(60)) u_mul_z (
    .clk(clk), .en(en), .a(64'(nq)), .b(OMF2_Q60), .neg(1'b0), .p(zm)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r <= $signed(64'(nq)) + (64'(alt_n) <<< 20);
      zq_r  <= zm + (64'(alt_z) <<< 20);
    end
  end

  g2e_dly #(.W(64), .D(T_RAD - T_SC)) u_dly_cp (
    .clk(clk), .en(en), .din(cp), .dout(cp_d)
  );

  g2e_dly #(.W(64), .D(T_PX - T_SC)) u_dly_sp (
    .clk(clk), .en(en), .din(sp), .dout(sp_d)
  );

  g2e_dly #(.W(64), .D(T_PX - T_SC)) u_dly_sl (
    .clk(clk), .en(en), .din(sl), .dout(sl_d)
  );

  g2e_dly #(.W(64), .D(T_PX - T_SC)) u_dly_cl (
    .clk(clk), .en(en), .din(cl), .dout(cl_d)
  );

  g2e_mul #(.SHIFT(60)) u_mul_px (
    .clk(clk), .en(en), .a(mag64(rad_r)), .b(mag64(cp_d)),
    .neg(rad_r[63] ^ cp_d[63]), .p(px)
  );

  g2e_mul #(.SHIFT(60)) u_mul_x (
    .clk(clk), .en(en), .a(mag64(px)), .b(mag64(cl_d)),
    .neg(px[63] ^ cl_d[63]), .p(xv)
  );

  g2e_mul #(.SHIFT(60)) u_mul_y (
    .clk(clk), .en(en), .a(mag64(px)), .b(mag64(sl_d)),
    .neg(px[63] ^ sl_d[63]), .p(yv)
  );

  g2e_mul #(.SHIFT(60)) u_mul_zz (
    .clk(clk), .en(en), .a(mag64(zq_r)), .b(mag64(sp_d)),
    .neg(zq_r[63] ^ sp_d[63]), .p(zv)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r <= 34'((xv + RND_HALF) >>> 20);
      ry_r <= 34'((yv + RND_HALF) >>> 20);
      rz_r <= 34'((zv + RND_HALF) >>> 20);
    end
  end

  // output buffer
  assign push = en && vld_r[T_OUT-1];
  assign pop  = out_valid && !out_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fx_r[wp_r] <= rx_r;
      fy_r[wp_r] <= ry_r;
      fz_r[wp_r] <= rz_r;
    end
  end

  assign out_valid  = (cnt_r != 2'd0);
  assign out_ecef_x = fx_r[rp_r];
  assign out_ecef_y = fy_r[rp_r];
  assign out_ecef_z = fz_r[rp_r];

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != 2'd2)
    else $error("result pushed into full output buffer");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("output buffer count lost a pop");

  a_frozen_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !en) |=> $stable(vld_r))
    else $error("pipeline moved while output buffer full");
`endif

endmodule

// ===== src/g2e_dly.sv =====
// g2e_dly: enable-gated delay line for pipeline sideband data
// uses no package
module g2e_dly #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sh_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= din;
      for (int i = 1; i < D; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
    end
  end

  assign dout = sh_r[D-1];

endmodule

// ===== src/g2e_mul.sv =====
// g2e_mul: two-stage 64x64 magnitude multiply from 32x32 partial products, shifted and signed
// depends on g2e_pkg
module g2e_mul import g2e_pkg::*; #(
  parameter int SHIFT = 60
) (
  input  logic               clk,
  input  logic               en,
  input  logic [63:0]        a,
  input  logic [63:0]        b,
  input  logic               neg,
  output logic signed [63:0] p
);

  logic [63:0] pp00_r, pp01_r, pp10_r, pp11_r;
  logic        neg_r;
  logic [127:0] full;
  logic [127:0] sh;
  logic [63:0]  m;
  logic signed [63:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r <= 64'(a[31:0])  * 64'(b[31:0]);
      pp01_r <= 64'(a[31:0])  * 64'(b[63:32]);
      pp10_r <= 64'(a[63:32]) * 64'(b[31:0]);
      pp11_r <= 64'(a[63:32]) * 64'(b[63:32]);
      neg_r  <= neg;
    end
  end

  always_comb begin
    full = {pp11_r, 64'd0} + {32'd0, pp01_r, 32'd0} + {32'd0, pp10_r, 32'd0}
         + {64'd0, pp00_r};
    sh   = full >> SHIFT;
    m    = {2'b00, sh[61:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= neg_r ? -$signed(m) : $signed(m);
    end
  end

  assign p = p_r;

endmodule

// ===== src/g2e_term_cell.sv =====
// g2e_term_cell: one taylor step, term * x^2, divided by a constant, negated and summed
// depends on g2e_pkg, g2e_mul, g2e_dly
module g2e_term_cell import g2e_pkg::*; #(
  parameter int DIV = 6
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] term_in,
  input  logic signed [63:0] sum_in,
  input  logic [63:0]        x2_in,
  output logic signed [63:0] term_out,
  output logic signed [63:0] sum_out,
  output logic [63:0]        x2_out
);

  localparam int RSH = 60 + $clog2(DIV);
  localparam logic [127:0] RECIP_W = (128'd1 << RSH) / DIV;
  localparam logic [63:0] RECIP = RECIP_W[63:0];
  localparam logic [63:0] DIV_C = 64'(DIV);

  logic signed [63:0] ps, qe;
  logic [63:0] ps_d;
  logic        tneg_d;
  logic [63:0] sum_d;
  logic [63:0] rem;
  logic [63:0] q_r;
  logic        tneg_r;
  logic signed [63:0] nt;
  logic signed [63:0] term_r, sum_r;

  g2e_mul #(.SHIFT(60)) u_mul_sq (
    .clk(clk), .en(en), .a(mag64(term_in)), .b(x2_in), .neg(1'b0), .p(ps)
  );

  g2e_mul #(.SHIFT(RSH)) u_mul_rcp (
    .clk(clk), .en(en), .a(ps), .b(RECIP), .neg(1'b0), .p(qe)
  );

  g2e_dly #(.W(64), .D(MUL_LAT)) u_dly_ps (
    .clk(clk), .en(en), .din(ps), .dout(ps_d)
  );

  g2e_dly #(.W(1), .D(2 * MUL_LAT)) u_dly_neg (
    .clk(clk), .en(en), .din(term_in[63]), .dout(tneg_d)
  );

  g2e_dly #(.W(64), .D(2 * MUL_LAT + 1)) u_dly_sum (
    .clk(clk), .en(en), .din(sum_in), .dout(sum_d)
  );

  g2e_dly #(.W(64), .D(CELL_LAT)) u_dly_x2 (
    .clk(clk), .en(en), .din(x2_in), .dout(x2_out)
  );

  assign rem = ps_d - 64'(qe) * DIV_C;

  always_ff @(posedge clk) begin
    if (en) begin
      q_r    <= 64'(qe) + 64'(rem >= DIV_C);
      tneg_r <= tneg_d;
    end
  end

  assign nt = tneg_r ? $signed(q_r) : -$signed(q_r);

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= nt;
      sum_r  <= $signed(sum_d) + nt;
    end
  end

  assign term_out = term_r;
  assign sum_out  = sum_r;

endmodule

// ===== src/g2e_sincos.sv =====
// g2e_sincos: clamp, quadrant split, radian scaling and a row of taylor cells each for sin and cos
// depends on g2e_pkg, g2e_mul, g2e_dly, g2e_term_cell
module g2e_sincos import g2e_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int LIMIT_DEG = 90
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] angle,
  output logic signed [63:0] sin_q,
  output logic signed [63:0] cos_q
);

  localparam logic signed [33:0] QUAD  = 34'(90 * (2 ** ANGLE_FRAC_BITS));
  localparam logic signed [33:0] LIM   = 34'(LIMIT_DEG) * (34'sd1 <<< ANGLE_FRAC_BITS);
  localparam logic signed [33:0] U_OFS = (QUAD <<< 1) + (QUAD >>> 1);
  localparam logic signed [33:0] Q2    = QUAD <<< 1;
  localparam logic signed [33:0] Q3    = QUAD * 34'sd3;
  localparam logic signed [33:0] Q4    = QUAD <<< 2;

  logic signed [33:0] ang_x, t, u, r;
  logic [2:0]  k;
  logic [29:0] rmag_r;
  logic        rneg_r;
  logic [1:0]  qd_r;
  logic signed [63:0] xm, x2, xm_d, x_s;
  logic        rneg_d;
  logic [1:0]  qd_d;
  logic signed [63:0] sn_r, cs_r;

  logic signed [63:0] s_term [TAYLOR_TERMS+1];
  logic signed [63:0] s_sum  [TAYLOR_TERMS+1];
  logic [63:0]        s_x2   [TAYLOR_TERMS+1];
  logic signed [63:0] c_term [TAYLOR_TERMS+1];
  logic signed [63:0] c_sum  [TAYLOR_TERMS+1];
  logic [63:0]        c_x2   [TAYLOR_TERMS+1];

  always_comb begin
    ang_x = 34'(angle);
    t = (ang_x > LIM) ? LIM : ((ang_x < -LIM) ? -LIM : ang_x);
    u = t + U_OFS;
    k = 3'(u >= QUAD) + 3'(u >= Q2) + 3'(u >= Q3) + 3'(u >= Q4);
    case (k)
      3'd0:    r = t + Q2;
      3'd1:    r = t + QUAD;
      3'd2:    r = t;
      3'd3:    r = t - QUAD;
      default: r = t - Q2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rmag_r <= r[33] ? 30'(-r) : 30'(r);
      rneg_r <= r[33];
      qd_r   <= 2'(k + 3'd2);
    end
  end

  g2e_mul #(.SHIFT(ANGLE_FRAC_BITS)) u_mul_x (
    .clk(clk), .en(en), .a(64'(rmag_r)), .b(DEG_Q60), .neg(1'b0), .p(xm)
  );

  g2e_mul #(.SHIFT(60)) u_mul_x2 (
    .clk(clk), .en(en), .a(xm), .b(xm), .neg(1'b0), .p(x2)
  );

  g2e_dly #(.W(64), .D(MUL_LAT)) u_dly_x (
    .clk(clk), .en(en), .din(xm), .dout(xm_d)
  );

  g2e_dly #(.W(1), .D(2 * MUL_LAT)) u_dly_neg (
    .clk(clk), .en(en), .din(rneg_r), .dout(rneg_d)
  );

  g2e_dly #(.W(2), .D(2 * MUL_LAT + TAYLOR_TERMS * CELL_LAT)) u_dly_qd (
    .clk(clk), .en(en), .din(qd_r), .dout(qd_d)
  );

  assign x_s = rneg_d ? -xm_d : xm_d;

  assign s_term[0] = x_s;
  assign s_sum[0]  = x_s;
  assign s_x2[0]   = x2;
  assign c_term[0] = ONE_Q60;
  assign c_sum[0]  = ONE_Q60;
  assign c_x2[0]   = x2;

  for (genvar n = 1; n <= TAYLOR_TERMS; n++) begin : g_cell
    g2e_term_cell #(.DIV((2 * n) * (2 * n + 1))) u_sin (
      .clk(clk), .en(en),
      .term_in(s_term[n-1]), .sum_in(s_sum[n-1]), .x2_in(s_x2[n-1]),
      .term_out(s_term[n]), .sum_out(s_sum[n]), .x2_out(s_x2[n])
    );
    g2e_term_cell #(.DIV((2 * n - 1) * (2 * n))) u_cos (
      .clk(clk), .en(en),
      .term_in(c_term[n-1]), .sum_in(c_sum[n-1]), .x2_in(c_x2[n-1]),
      .term_out(c_term[n]), .sum_out(c_sum[n]), .x2_out(c_x2[n])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (qd_d)
        2'd0: begin
          sn_r <= s_sum[TAYLOR_TERMS];
          cs_r <= c_sum[TAYLOR_TERMS];
        end
        2'd1: begin
          sn_r <= c_sum[TAYLOR_TERMS];
          cs_r <= -s_sum[TAYLOR_TERMS];
        end
        2'd2: begin
          sn_r <= -s_sum[TAYLOR_TERMS];
          cs_r <= -c_sum[TAYLOR_TERMS];
        end
        default: begin
          sn_r <= -c_sum[TAYLOR_TERMS];
          cs_r <= s_sum[TAYLOR_TERMS];
        end
      endcase
    end
  end

  assign sin_q = sn_r;
  assign cos_q = cs_r;

endmodule

// ===== src/g2e_radius.sv =====
// g2e_radius: bit-per-stage square root and restoring divider giving the prime-vertical radius
// depends on g2e_pkg
module g2e_radius import g2e_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [61:0]          w,
  output logic [QUOT_BITS-1:0] nq
);

  localparam logic [DIV_W-1:0] NUM = DIV_W'(EQ_RADIUS_MM) << 80;

  logic [REM_W-1:0]  rem_r [ROOT_STEPS];
  logic [ROOT_W-1:0] root_r [ROOT_STEPS];
  logic [RDC_W-1:0]  rdc_r [ROOT_STEPS];

  logic [DIV_W-1:0]     drem_r [QUOT_BITS];
  logic [ROOT_W-1:0]    dden_r [QUOT_BITS];
  logic [QUOT_BITS-1:0] dq_r [QUOT_BITS];

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
    logic [REM_W-1:0]  rem_i, rem_s, trial;
    logic [ROOT_W-1:0] root_i;
    logic [RDC_W-1:0]  rdc_i;
    logic              ge;
    if (j == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign rdc_i  = {w, 60'd0};
    end else begin : g_next
      assign rem_i  = rem_r[j-1];
      assign root_i = root_r[j-1];
      assign rdc_i  = rdc_r[j-1];
    end
    assign rem_s = {rem_i[REM_W-3:0], rdc_i[RDC_W-1:RDC_W-2]};
    assign trial = {3'd0, root_i, 2'b01};
    assign ge    = rem_s >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= ge ? rem_s - trial : rem_s;
        root_r[j] <= {root_i[ROOT_W-2:0], ge};
        rdc_r[j]  <= rdc_i << 2;
      end
    end
  end

  for (genvar j = 0; j < QUOT_BITS; j++) begin : g_quot
    localparam int B = QUOT_BITS - 1 - j;
    logic [DIV_W-1:0]     rem_i, trial;
    logic [ROOT_W-1:0]    den_i;
    logic [QUOT_BITS-1:0] q_i, q_n;
    logic                 ge;
    if (j == 0) begin : g_first
      assign rem_i = NUM;
      assign den_i = root_r[ROOT_STEPS-1];
      assign q_i   = '0;
    end else begin : g_next
      assign rem_i = drem_r[j-1];
      assign den_i = dden_r[j-1];
      assign q_i   = dq_r[j-1];
    end
    assign trial = DIV_W'(den_i) << B;
    assign ge    = rem_i >= trial;
    always_comb begin
      q_n    = q_i;
      q_n[B] = ge;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[j] <= ge ? rem_i - trial : rem_i;
        dden_r[j] <= den_i;
        dq_r[j]   <= q_n;
      end
    end
  end

  assign nq = dq_r[QUOT_BITS-1];

endmodule

// ===== verif/geodetic_to_ecef_checker.sv =====
// geodetic_to_ecef_checker: watches both channels of geodetic_to_ecef, predicts each
// ecef position from the geodetic request and compares it field by field
// depends on nothing but the signals of the block's ports
`timescale 1ns / 100ps

module geodetic_to_ecef_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [30:0] in_latitude,
  input  logic signed [31:0] in_longitude,
  input  logic signed [27:0] in_altitude,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [33:0] out_ecef_x,
  input  logic signed [33:0] out_ecef_y,
  input  logic signed [33:0] out_ecef_z,
  output int                 errors,
  output int                 pending
);

  localparam int FRAC = 23;
  localparam logic [63:0] PI_FX = 64'h3243F6A8885A308D;
  localparam logic [63:0] DEG_FX = PI_FX / 64'd180;
  localparam logic signed [63:0] UNIT = 64'sd1 <<< 60;
  localparam logic [63:0] RADIUS_A = 64'd6378137000;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } ecef_t;

  ecef_t ecef_q[$];

  function automatic logic [63:0] abs_u(input logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                input logic signed [63:0] b,
                                                input int s);
    logic [127:0] p;
    logic [63:0] m;
    p = ({64'd0, abs_u(a)} * {64'd0, abs_u(b)}) >> s;
    m = p[63:0] & ((64'd1 << 62) - 64'd1);
    return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
  endfunction

  task automatic sin_cos(input logic signed [63:0] t, output logic signed [63:0] sn,
                         output logic signed [63:0] cs);
    logic signed [63:0] quad, k, r, x, x2, st, ct, ss, cc, d1, d2;
    logic [127:0] p;
    logic [1:0] qd;
    quad = 64'sd90 <<< FRAC;
    k = (t + 2 * quad + quad / 2) / quad;
    r = t + 2 * quad - k * quad;
    qd = k[1:0] + 2'd2;
    p = {64'd0, abs_u(r)} * {64'd0, DEG_FX};
    x = $signed(p[63 + FRAC -: 64]);
    if (r < 0) x = -x;
    x2 = fx_mul(x, x, 60);
    st = x;
    ss = x;
    ct = UNIT;
    cc = UNIT;
    for (int n = 1; n <= 12; n++) begin
      d1 = (2 * n) * (2 * n + 1);
      d2 = (2 * n - 1) * (2 * n);
      st = -fx_mul(st, x2, 60) / d1;
      ct = -fx_mul(ct, x2, 60) / d2;
      ss += st;
      cc += ct;
    end
    case (qd)
      2'd0: begin sn = ss; cs = cc; end
      2'd1: begin sn = cc; cs = -ss; end
      2'd2: begin sn = -ss; cs = -cc; end
      default: begin sn = -cc; cs = ss; end
    endcase
  endtask

  function automatic logic signed [33:0] round_mm(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v + (64'sd1 <<< 19)) >>> 20;
    return t[33:0];
  endfunction

  task automatic predict_ecef(input logic signed [30:0] lat_in,
                              input logic signed [31:0] lon_in,
                              input logic signed [27:0] alt_in, output ecef_t e);
    logic signed [63:0] lat, lon, alt, lim, fq, e2, omf2, sp, cp, sl, cl, w, nq, rad, px;
    logic [127:0] rdc, root, rem, trial, q;
    lat = lat_in;
    lim = 64'sd90 <<< FRAC;
    if (lat > lim) lat = lim;
    if (lat < -lim) lat = -lim;
    lon = lon_in;
    lim = 64'sd180 <<< FRAC;
    if (lon > lim) lon = lim;
    if (lon < -lim) lon = -lim;
    alt = alt_in;
    q = (128'd1000000000 << 60) / 128'd298257223563;
    fq = $signed(q[63:0]);
    e2 = 2 * fq - fx_mul(fq, fq, 60);
    omf2 = fx_mul(UNIT - fq, UNIT - fq, 60);
    sin_cos(lat, sp, cp);
    sin_cos(lon, sl, cl);
    w = UNIT - fx_mul(e2, fx_mul(sp, sp, 60), 60);
    rdc = {64'd0, w} << 60;
    root = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | ((rdc >> (2 * i)) & 128'd3);
      trial = (root << 2) | 128'd1;
      root = root << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 128'd1;
      end
    end
    q = ({64'd0, RADIUS_A} << 80) / root;
    nq = $signed(q[63:0]);
    rad = nq + alt * (64'sd1 <<< 20);
    px = fx_mul(rad, cp, 60);
    e.x = round_mm(fx_mul(px, cl, 60));
    e.y = round_mm(fx_mul(px, sl, 60));
    e.z = round_mm(fx_mul(fx_mul(nq, omf2, 60) + alt * (64'sd1 <<< 20), sp, 60));
  endtask

  task automatic report(input string what, input logic signed [33:0] got,
                        input logic signed [33:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    ecef_t e;
    if (rst_n && in_valid && !in_stall) begin
      predict_ecef(in_latitude, in_longitude, in_altitude, e);
      ecef_q.push_back(e);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (ecef_q.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        errors++;
      end else begin
        e = ecef_q.pop_front();
        if (out_ecef_x !== e.x) report("ecef_x", out_ecef_x, e.x);
        if (out_ecef_y !== e.y) report("ecef_y", out_ecef_y, e.y);
        if (out_ecef_z !== e.z) report("ecef_z", out_ecef_z, e.z);
      end
    end
    pending <= ecef_q.size();
  end

  initial pending = 0;

endmodule

// ===== verif/geodetic_to_ecef_tb.sv =====
// geodetic_to_ecef_tb: drives directed and random geodetic requests into geodetic_to_ecef
// under varying idle and stall patterns; depends on the block and geodetic_to_ecef_checker
`timescale 1ns / 100ps

module geodetic_to_ecef_tb;

  localparam int LIMIT = 300000;
  localparam logic signed [31:0] DEG90 = 32'sd90 <<< 23;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [30:0] in_latitude = '0;
  logic signed [31:0] in_longitude = '0;
  logic signed [27:0] in_altitude = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [33:0] out_ecef_x, out_ecef_y, out_ecef_z;
  int errors, pending;
  int send_idle = 32, recv_idle = 85;
  int hold_req = 0, hold_cnt = 0;
  int cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  geodetic_to_ecef i_dut (.*);

  geodetic_to_ecef_checker i_checker (.*);

  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom % 100) < recv_idle;
    end
  end

  task automatic send_position(input logic signed [30:0] lat, input logic signed [31:0] lon,
                               input logic signed [27:0] alt);
    in_valid <= 1'b1;
    in_latitude <= lat;
    in_longitude <= lon;
    in_altitude <= alt;
    do @(posedge clk); while (in_stall);
    while (($urandom % 100) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_random(input int count);
    logic signed [31:0] lat, lon, alt;
    repeat (count) begin
      case ($urandom % 8)
        0: begin
          lat = $urandom;
          lon = $urandom;
          alt = $urandom;
        end
        1: begin
          lat = ($signed($urandom_range(0, 8)) - 4) * (DEG90 / 2)
              + ($signed($urandom_range(0, 4)) - 2);
          lon = ($signed($urandom_range(0, 4)) - 2) * DEG90
              + ($signed($urandom_range(0, 4)) - 2);
          alt = $urandom_range(0, 101000000) - 1000000;
        end
        default: begin
          lat = $urandom_range(0, 1509949440) - 754974720;
          lon = $urandom_range(0, 32'd3019898880) - 1509949440;
          alt = $urandom_range(0, 101000000) - 1000000;
        end
      endcase
      send_position(lat[30:0], lon, alt[27:0]);
    end
  endtask

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_position(31'sd754974720, 32'sd0, 28'sd0);
    send_position(-31'sd754974720, 32'sd0, 28'sd0);
    send_position(31'sh3fffffff, 32'sh7fffffff, 28'sh7ffffff);
    send_position(-31'sh40000000, -32'sh80000000, -28'sh8000000);
    send_position(31'sd0, 32'sd1509949440, 28'sd0);
    send_position(31'sd0, -32'sd1509949440, 28'sd100000000);
    send_position(31'sd0, 32'sd0, -28'sd1000000);
    send_position(31'sd0, 32'sd0, 28'sd100000000);
    send_position(31'(DEG90 / 2), 32'(DEG90 / 2), 28'sd1234);
    send_position(-31'(DEG90 / 2), -32'(DEG90 / 2), -28'sd1234);
    send_position(31'(DEG90 / 2 - 1), 32'(DEG90), 28'sd1);
    send_position(-31'(DEG90 / 2 + 1), -32'(DEG90), -28'sd1);
    send_position(31'sd1, 32'(3 * DEG90 / 2), 28'sd0);
    send_position(-31'sd1, -32'(3 * DEG90 / 2), 28'sd0);
    send_position(31'sd754974721, 32'sd1509949441, 28'sd5);
    send_position(-31'sd754974721, -32'sd1509949441, -28'sd5);
    send_random(180);
    send_idle = 85;
    recv_idle = 32;
    send_random(180);
    send_idle = 0;
    recv_idle = 0;
    hold_req = 500;
    send_random(240);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (errors == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
